>>> rtl/utv_pkg.sv
// ============================================================================
// utv_pkg - shared types and constants for the UTF-8 text validator
// Widths, verdict codes and the per-string decoder state record.
// ============================================================================
package utv_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned MAX_LEN_W = 12;
    localparam int unsigned COUNT_W   = 13;
    localparam int unsigned ACCUM_W   = 21;
    localparam int unsigned PEND_W    = 2;

    localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = 12'd1024;
    localparam logic [COUNT_W-1:0]   COUNT_MAX     = 13'h1fff;

    // Code point limits
    localparam logic [ACCUM_W-1:0] CP_MIN_2BYTE  = 21'h000080;
    localparam logic [ACCUM_W-1:0] CP_MIN_3BYTE  = 21'h000800;
    localparam logic [ACCUM_W-1:0] CP_MIN_4BYTE  = 21'h010000;
    localparam logic [ACCUM_W-1:0] CP_MAX        = 21'h10ffff;
    localparam logic [ACCUM_W-1:0] SURR_LO       = 21'h00d800;
    localparam logic [ACCUM_W-1:0] SURR_HI       = 21'h00dfff;

    // Result codes
    typedef enum logic [1:0] {
        VERDICT_VALID     = 2'd0,
        VERDICT_TOO_LONG  = 2'd1,
        VERDICT_MALFORMED = 2'd2
    } verdict_t;

    // Decoder state carried from byte to byte within one string
    typedef struct packed {
        logic [PEND_W-1:0]  pending;
        logic [PEND_W-1:0]  seq_len;
        logic [ACCUM_W-1:0] accum;
        logic               error_seen;
        logic [COUNT_W-1:0] byte_count;
    } utv_state_t;

endpackage

>>> rtl/utv_step.sv
// ============================================================================
// utv_step - one-byte UTF-8 decode step
// Advances the per-string decoder state by one byte and forms the verdict
// that would be reported if this byte ends the string.
// ============================================================================
module utv_step
    import utv_pkg::*;
(
    input  utv_state_t             cur,
    input  logic [BYTE_W-1:0]      data_byte,
    input  logic [MAX_LEN_W-1:0]   max_text_bytes,
    output utv_state_t             nxt,
    output verdict_t               verdict
);

    logic seq_bad;

    always_comb
    begin
        nxt     = cur;
        seq_bad = 1'b0;

        // Saturating length count, includes every byte
        if (cur.byte_count != COUNT_MAX)
        begin
            nxt.byte_count = cur.byte_count + 1'b1;
        end

        // Decoding stops once the string is known bad
        if (!cur.error_seen)
        begin
            if (cur.pending == '0)
            begin
                // Expecting a lead byte
                if (data_byte[7] == 1'b0)
                begin
                    nxt.pending = cur.pending;
                end
                else if (data_byte[7:5] == 3'b110)
                begin
                    nxt.pending = 2'd1;
                    nxt.seq_len = 2'd1;
                    nxt.accum   = {16'd0, data_byte[4:0]};
                end
                else if (data_byte[7:4] == 4'b1110)
                begin
                    nxt.pending = 2'd2;
                    nxt.seq_len = 2'd2;
                    nxt.accum   = {17'd0, data_byte[3:0]};
                end
                else if (data_byte[7:3] == 5'b11110)
                begin
                    nxt.pending = 2'd3;
                    nxt.seq_len = 2'd3;
                    nxt.accum   = {18'd0, data_byte[2:0]};
                end
                else
                begin
                    nxt.error_seen = 1'b1;
                end
            end
            else if (data_byte[7:6] != 2'b10)
            begin
                // Bad continuation byte
                nxt.error_seen = 1'b1;
                nxt.pending    = '0;
            end
            else
            begin
                nxt.accum   = {cur.accum[ACCUM_W-7:0], data_byte[5:0]};
                nxt.pending = cur.pending - 1'b1;

                // Completed sequence: overlong, out of range or surrogate
                seq_bad = ((cur.seq_len == 2'd1) && (nxt.accum < CP_MIN_2BYTE)) ||
                          ((cur.seq_len == 2'd2) && (nxt.accum < CP_MIN_3BYTE)) ||
                          ((cur.seq_len == 2'd3) && (nxt.accum < CP_MIN_4BYTE)) ||
                          (nxt.accum > CP_MAX) ||
                          (nxt.accum inside {[SURR_LO:SURR_HI]});
                if ((nxt.pending == '0) && seq_bad)
                begin
                    nxt.error_seen = 1'b1;
                end
            end
        end

        // Verdict if this byte closes the string; length wins
        if (nxt.byte_count > {1'b0, max_text_bytes})
        begin
            verdict = VERDICT_TOO_LONG;
        end
        else if (nxt.error_seen || (nxt.pending != '0))
        begin
            verdict = VERDICT_MALFORMED;
        end
        else
        begin
            verdict = VERDICT_VALID;
        end
    end

endmodule

>>> rtl/utf8_text_validator_core.sv
// ============================================================================
// utf8_text_validator_core - streaming UTF-8 validator with length limit
// Checks one text string per frame, one byte per item, and returns one
// verdict item per frame.
// ============================================================================
// Bytes of a string arrive one per item on s_axis, the final byte marked by
// tlast. The block takes one byte every clock while m_axis is not stalled. A
// byte accepted from s_axis sits in the input register until the decode step
// consumes it. When a final byte is consumed its verdict is registered in the
// result register and held on m_axis until taken. The rate is set by the
// single decoder state register, which is updated once per byte by a short
// combinational step. While a verdict waits on m_axis the decoder holds, the
// input register takes one more byte, and s_axis then stalls until the verdict
// is taken. Verdict codes: 0 valid, 1 longer than max_text_bytes, 2 malformed.
// max_text_bytes resets to 1024 and is written through cfg_wr_en / cfg_wr_data
// by the user only while idle; the block itself does not enforce this.
module utf8_text_validator_core
    import utv_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    // Configuration
    input  logic                 cfg_wr_en,
    input  logic [MAX_LEN_W-1:0] cfg_wr_data,    // max_text_bytes

    // Byte stream in
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [7:0] data_byte
    input  logic                 s_axis_tlast,   // last

    // Verdict out
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [7:0]           m_axis_tdata    // [1:0] verdict, [7:2] zero
);

    logic [MAX_LEN_W-1:0] max_len_reg;

    logic                 in_valid_reg;
    logic [BYTE_W-1:0]    in_byte_reg;
    logic                 in_last_reg;

    utv_state_t           state_reg;
    utv_state_t           state_next;
    utv_state_t           step_state;
    verdict_t             step_verdict;

    logic                 out_valid_reg;
    verdict_t             out_verdict_reg;

    logic                 advance;
    logic                 consume;
    logic                 in_take;

    // Handshake control
    assign advance       = !out_valid_reg || m_axis_tready;
    assign consume       = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_LEN_RESET;
        end
        else if (cfg_wr_en)
        begin
            max_len_reg <= cfg_wr_data;
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    // Decode step
    utv_step u_step (
        .cur            (state_reg),
        .data_byte      (in_byte_reg),
        .max_text_bytes (max_len_reg),
        .nxt            (step_state),
        .verdict        (step_verdict)
    );

    // Clear the string state after its final byte
    always_comb
    begin
        state_next = state_reg;
        if (consume)
        begin
            state_next = in_last_reg ? utv_state_t'('0) : step_state;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= consume && in_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (consume && in_last_reg)
        begin
            out_verdict_reg <= step_verdict;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_verdict_reg};

`ifndef SYNTHESIS
    // A verdict appears only after a final byte went through the decode step
    a_verdict_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(consume && in_last_reg))
        else $error("verdict without a final byte");

    // Pending continuation bytes never coexist with a sticky error
    a_pending_no_error: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.pending != '0) |-> !state_reg.error_seen)
        else $error("pending count left set after an error");

    // Pending count never exceeds the length of the open sequence
    a_pending_le_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.pending <= state_reg.seq_len))
        else $error("pending count above sequence length");

    // String state is cleared right after a final byte is decoded
    a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (consume && in_last_reg) |=> (state_reg.byte_count == '0))
        else $error("string state not cleared after final byte");
`endif

endmodule
